FILE: design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and codes for the complex arithmetic unit
// operation codes and result status codes
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

endpackage

FILE: design/cau_div_pipe.sv
// ----------------------------------------------------------------------------
// cau_div_pipe: pipelined unsigned restoring divider
// one quotient bit per stage, quotient bits above the result range flag overflow
// ----------------------------------------------------------------------------
module cau_div_pipe #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33,
  parameter int Q_W   = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic             big_o
);

  localparam int RW = DEN_W + 1;

  logic             vld_q [0:NUM_W];
  logic [NUM_W-1:0] num_q [0:NUM_W];
  logic [DEN_W-1:0] den_q [0:NUM_W];
  logic [RW-1:0]    rem_q [0:NUM_W];
  logic [Q_W-1:0]   quo_q [0:NUM_W];
  logic             big_q [0:NUM_W];

  assign vld_q[0] = valid_i;
  assign num_q[0] = num_i;
  assign den_q[0] = den_i;
  assign rem_q[0] = '0;
  assign quo_q[0] = '0;
  assign big_q[0] = 1'b0;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    localparam int BI = NUM_W - 1 - s;
    logic [RW-1:0] sh, df;
    logic          ge;
    always_comb begin
      sh = {rem_q[s][RW-2:0], num_q[s][BI]};
      ge = sh >= {1'b0, den_q[s]};
      df = ge ? sh - {1'b0, den_q[s]} : sh;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_q[s];
      den_q[s+1] <= den_q[s];
      rem_q[s+1] <= df;
      if (BI >= Q_W) begin
        quo_q[s+1] <= quo_q[s];
        big_q[s+1] <= big_q[s] | ge;
      end else begin
        quo_q[s+1] <= quo_q[s] | (Q_W'(ge) << BI);
        big_q[s+1] <= big_q[s];
      end
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quot_o  = quo_q[NUM_W];
  assign big_o   = big_q[NUM_W];

endmodule

FILE: design/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex add, subtract, multiply and divide
// signed fixed point operands, saturated results with a status code
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | operation_i, first_*_i, second_*_i
//  result   | done_o (strobe)    | result_real_o, result_imag_o, status_o
//
// every op flows through the same pipeline, so latency is fixed for all ops:
// 3 front stages (products, sums, sign/magnitude), one stage per bit of the
// divider numerator (2*DATA_WIDTH+FRAC_BITS), then one clamp/output stage.
// one beat is accepted every cycle; busy is tied low.
// reset clears only the valid bits; payload registers are not reset.
// the receiver cannot stall, so no back pressure exists anywhere.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] first_real_i,
  input  logic signed [DATA_WIDTH-1:0] first_imag_i,
  input  logic signed [DATA_WIDTH-1:0] second_real_i,
  input  logic signed [DATA_WIDTH-1:0] second_imag_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_real_o,
  output logic signed [DATA_WIDTH-1:0] result_imag_o,
  output logic [1:0]                   status_o
);

  // product width, sum width (one guard bit), divisor width
  localparam int PW  = 2 * DATA_WIDTH;
  localparam int SW  = PW + 1;
  localparam int DW  = PW;          // c*c + d*d fits in 2*DATA_WIDTH unsigned
  localparam int NW  = PW + FRAC_BITS; // |sum| << FRAC_BITS, magnitude bits
  localparam int QW  = DATA_WIDTH + 1; // quotient range that matters for clamp
  localparam int DLAT = NW;

  assign busy = 1'b0;

  // ---------------- stage 1: the four cross products, the two squares and the add/sub sums
  logic              v1_q;
  op_e               op1_q;
  logic signed [PW-1:0] ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic signed [DATA_WIDTH:0] sr_q, si_q;
  logic              z1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= op_e'(operation_i);
    ac_q  <= PW'(first_real_i) * PW'(second_real_i);
    bd_q  <= PW'(first_imag_i) * PW'(second_imag_i);
    ad_q  <= PW'(first_real_i) * PW'(second_imag_i);
    bc_q  <= PW'(first_imag_i) * PW'(second_real_i);
    cc_q  <= PW'(second_real_i) * PW'(second_real_i);
    dd_q  <= PW'(second_imag_i) * PW'(second_imag_i);
    z1_q  <= (second_real_i == '0) && (second_imag_i == '0);
    if (op_e'(operation_i) == OP_SUB) begin
      sr_q <= (DATA_WIDTH+1)'(first_real_i) - (DATA_WIDTH+1)'(second_real_i);
      si_q <= (DATA_WIDTH+1)'(first_imag_i) - (DATA_WIDTH+1)'(second_imag_i);
    end else begin
      sr_q <= (DATA_WIDTH+1)'(first_real_i) + (DATA_WIDTH+1)'(second_real_i);
      si_q <= (DATA_WIDTH+1)'(first_imag_i) + (DATA_WIDTH+1)'(second_imag_i);
    end
  end

  // ---------------- stage 2: combine products per operation
  logic              v2_q;
  op_e               op2_q;
  logic              z2_q;
  logic signed [SW-1:0] re2_q, im2_q;
  logic [DW-1:0]     den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q  <= op1_q;
    z2_q   <= z1_q;
    den2_q <= DW'(cc_q) + DW'(dd_q);
    case (op1_q)
      OP_ADD, OP_SUB: begin
        re2_q <= SW'(sr_q);
        im2_q <= SW'(si_q);
      end
      OP_MUL: begin
        re2_q <= SW'(ac_q) - SW'(bd_q);
        im2_q <= SW'(ad_q) + SW'(bc_q);
      end
      default: begin
        re2_q <= SW'(ac_q) + SW'(bd_q);
        im2_q <= SW'(bc_q) - SW'(ad_q);
      end
    endcase
  end

  // ---------------- stage 3: sign/magnitude, multiply scaling
  logic              v3_q;
  op_e               op3_q;
  logic              z3_q;
  logic              nr3_q, ni3_q;
  logic [SW-1:0]     mr3_q, mi3_q;
  logic [DW-1:0]     den3_q;
  logic [SW-1:0]     mr_abs, mi_abs;
  localparam logic [SW-1:0] RND = SW'((64'd1 << FRAC_BITS) - 64'd1);

  always_comb begin
    mr_abs = re2_q[SW-1] ? SW'(-re2_q) : SW'(re2_q);
    mi_abs = im2_q[SW-1] ? SW'(-im2_q) : SW'(im2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q  <= op2_q;
    z3_q   <= z2_q;
    den3_q <= den2_q;
    nr3_q  <= re2_q[SW-1];
    ni3_q  <= im2_q[SW-1];
    if (op2_q == OP_MUL) begin
      // negative magnitudes round up so the result floors
      mr3_q <= re2_q[SW-1] ? (mr_abs + RND) >> FRAC_BITS : mr_abs >> FRAC_BITS;
      mi3_q <= im2_q[SW-1] ? (mi_abs + RND) >> FRAC_BITS : mi_abs >> FRAC_BITS;
    end else begin
      mr3_q <= mr_abs;
      mi3_q <= mi_abs;
    end
  end

  // ---------------- divider: magnitudes shifted by the fraction bits
  logic          dv_r, dv_i;
  logic [QW-1:0] qr, qi;
  logic          br, bi;
  logic [NW-1:0] numr, numi;

  // |sum| is at most 2^(PW-1), so the shifted magnitude fits in NW bits
  assign numr = NW'(mr3_q) << FRAC_BITS;
  assign numi = NW'(mi3_q) << FRAC_BITS;

  cau_div_pipe #(.NUM_W(NW), .DEN_W(DW), .Q_W(QW)) u_div_re (
    .clk_i, .rst_ni,
    .valid_i (v3_q),
    .num_i   (numr),
    .den_i   (den3_q),
    .valid_o (dv_r),
    .quot_o  (qr),
    .big_o   (br)
  );

  cau_div_pipe #(.NUM_W(NW), .DEN_W(DW), .Q_W(QW)) u_div_im (
    .clk_i, .rst_ni,
    .valid_i (v3_q),
    .num_i   (numi),
    .den_i   (den3_q),
    .valid_o (dv_i),
    .quot_o  (qi),
    .big_o   (bi)
  );

  // side delay line for the non-divide data, matched to the divider latency
  logic          dv_q  [0:DLAT];
  logic [1:0]    dop_q [0:DLAT];
  logic          dz_q  [0:DLAT];
  logic          dnr_q [0:DLAT];
  logic          dni_q [0:DLAT];
  logic [SW-1:0] dmr_q [0:DLAT];
  logic [SW-1:0] dmi_q [0:DLAT];

  assign dv_q[0]  = v3_q;
  assign dop_q[0] = op3_q;
  assign dz_q[0]  = z3_q;
  assign dnr_q[0] = nr3_q;
  assign dni_q[0] = ni3_q;
  assign dmr_q[0] = mr3_q;
  assign dmi_q[0] = mi3_q;

  for (genvar k = 0; k < DLAT; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      dop_q[k+1] <= dop_q[k];
      dz_q[k+1]  <= dz_q[k];
      dnr_q[k+1] <= dnr_q[k];
      dni_q[k+1] <= dni_q[k];
      dmr_q[k+1] <= dmr_q[k];
      dmi_q[k+1] <= dmi_q[k];
    end
  end

  // ---------------- output stage: select, clamp, status
  localparam logic [SW-1:0] MAXNEG = SW'(64'd1 << (DATA_WIDTH - 1));
  localparam logic [SW-1:0] MAXPOS = MAXNEG - SW'(1);

  logic              is_div, is_z;
  logic [SW-1:0]     magr, magi;
  logic              bgr, bgi, satr, sati;
  logic signed [DATA_WIDTH-1:0] rr_d, ri_d;
  status_e           st_d;
  logic              done_q;
  logic signed [DATA_WIDTH-1:0] rr_q, ri_q;
  status_e           st_q;

  always_comb begin
    is_div = op_e'(dop_q[DLAT]) == OP_DIV;
    is_z   = is_div && dz_q[DLAT];
    magr   = is_div ? SW'(qr) : dmr_q[DLAT];
    magi   = is_div ? SW'(qi) : dmi_q[DLAT];
    bgr    = is_div && br;
    bgi    = is_div && bi;
    if (dnr_q[DLAT]) begin
      satr = bgr || (magr > MAXNEG);
      rr_d = satr ? DATA_WIDTH'(-MAXNEG) : DATA_WIDTH'(-magr);
    end else begin
      satr = bgr || (magr > MAXPOS);
      rr_d = satr ? DATA_WIDTH'(MAXPOS) : DATA_WIDTH'(magr);
    end
    if (dni_q[DLAT]) begin
      sati = bgi || (magi > MAXNEG);
      ri_d = sati ? DATA_WIDTH'(-MAXNEG) : DATA_WIDTH'(-magi);
    end else begin
      sati = bgi || (magi > MAXPOS);
      ri_d = sati ? DATA_WIDTH'(MAXPOS) : DATA_WIDTH'(magi);
    end
    if (is_z) begin
      rr_d = '0;
      ri_d = '0;
      st_d = ST_DIV0;
    end else if (satr || sati) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[DLAT];
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q <= rr_d;
    ri_q <= ri_d;
    st_q <= st_d;
  end

  assign done_o        = done_q;
  assign result_real_o = rr_q;
  assign result_imag_o = ri_q;
  assign status_o      = st_q;

  // ---------------- checks
  // divider lanes run in lockstep with the side delay line
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_r == dv_q[DLAT]) && (dv_i == dv_q[DLAT]))
    else $error("divider valid out of step with side pipeline");

  // a beat accepted now leaves after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(DLAT + 4) done_o)
    else $error("result strobe missing after fixed latency");

  // division by zero always returns zero components
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DIV0) |-> (result_real_o == '0 && result_imag_o == '0))
    else $error("division by zero returned nonzero result");

endmodule
